### src/kai_pkg.sv
`timescale 1ns / 1ps

package kai_pkg;

  localparam int MAX_SEGMENTS_DEF  = 16;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int TIME_W  = 32;
  localparam int ANGLE_W = 32;
  localparam int INDEX_W = 5;
  localparam int COUNT_W = 5;
  localparam int SEG_W   = 4;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  typedef struct packed {
    logic end_we;
    logic ang_we;
  } kai_wr_ctl_t;

endpackage

### src/kai_if.sv
`timescale 1ns / 1ps

interface kai_query_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [kai_pkg::INDEX_W-1:0]         entry_index;
  logic [kai_pkg::TIME_W-1:0]          entry_end_time;
  logic signed [kai_pkg::ANGLE_W-1:0]  entry_angle;
  logic [kai_pkg::TIME_W-1:0]          query_time;

  modport source (output valid, action, entry_index, entry_end_time, entry_angle, query_time,
                  input ready);
  modport sink (input valid, action, entry_index, entry_end_time, entry_angle, query_time,
                output ready);
endinterface

interface kai_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [kai_pkg::ANGLE_W-1:0]  angle_out;
  logic [kai_pkg::SEG_W-1:0]           segment_used;
  logic                                past_end;

  modport source (output valid, angle_out, segment_used, past_end, input ready);
  modport sink (input valid, angle_out, segment_used, past_end, output ready);
endinterface

### src/keyframe_angle_interpolator_top.sv
`timescale 1ns / 1ps

// Piecewise linear keyframe interpolator. A load beat (action 0) writes one end time (index below
// MAX_SEGMENTS) and one angle (index up to MAX_SEGMENTS) into the keyframe table. An evaluate beat
// (action 1) returns one result beat with the interpolated Q8.24 angle, the segment used and a
// past-end flag. The evaluation runs the segment search, the fetch of the segment's bounds and
// angles, the divider, a multiply and a sum before the result is staged; a segment whose end time
// is not above its start skips the divider. The search walks the table's single end-time read port
// one end time per cycle, and the bit-serial divider yields one fraction bit per cycle. A query at
// or past the last end time goes from S_LAST straight to S_DONE. The query channel is not ready
// while an evaluation is in flight; the result sits in an output register until taken. Table
// entries are undefined until loaded; segment_count may be written only while the block is idle.
module keyframe_angle_interpolator_top #(
  parameter int MAX_SEGMENTS  = kai_pkg::MAX_SEGMENTS_DEF,
  parameter int FRACTION_BITS = kai_pkg::FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  kai_query_if.sink                   query,
  kai_result_if.source                result,
  input  logic                        seg_count_we,
  input  logic [kai_pkg::COUNT_W-1:0] seg_count_wdata
);

  localparam int CW     = $clog2(MAX_SEGMENTS + 1);
  localparam int END_AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int TW     = kai_pkg::TIME_W;
  localparam int AW     = kai_pkg::ANGLE_W;
  localparam int QW     = FRACTION_BITS + 1;
  localparam int PW     = AW + QW + 2;

  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_HINT, S_PREV, S_SCAN, S_FETCH, S_GET0, S_GET1,
    S_DIV, S_MUL, S_SUM, S_DONE
  } state_t;

  state_t                      state;
  logic [kai_pkg::COUNT_W-1:0] seg_count;
  logic [CW-1:0]               hint;
  logic [CW-1:0]               h;
  logic [TW-1:0]               t_r;
  logic [TW-1:0]               stop_r;
  logic signed [AW-1:0]        a0;
  logic signed [AW:0]          diff;
  logic [QW-1:0]               frac;
  logic signed [PW-1:0]        prod;
  logic signed [AW-1:0]        res_angle;
  logic [CW-1:0]               res_seg;
  logic                        res_past;
  logic                        out_valid;

  logic [CW-1:0]               n_eff;
  logic [CW-1:0]               h0;
  logic                        load_beat;
  logic                        eval_beat;
  kai_pkg::kai_wr_ctl_t        wr_ctl;
  logic [END_AW-1:0]           rd_end_addr;
  logic [CW-1:0]               rd_ang_addr;
  logic [TW-1:0]               end_rd;
  logic [AW-1:0]               ang_rd;
  logic [TW-1:0]               start_v;
  logic                        div_start;
  logic [TW-1:0]               div_num;
  logic [TW-1:0]               div_den;
  logic                        div_done;
  logic [QW-1:0]               div_quot;
  logic signed [PW-1:0]        prod_sh;

  always_comb begin
    if (seg_count == '0) begin
      n_eff = CW'(1);
    end else if (32'(seg_count) > 32'(MAX_SEGMENTS)) begin
      n_eff = CW'(MAX_SEGMENTS);
    end else begin
      n_eff = CW'(seg_count);
    end
  end

  assign h0 = (hint >= n_eff) ? '0 : hint;

  assign query.ready = (state == S_IDLE);
  assign load_beat   = query.valid && query.ready && (query.action == kai_pkg::ACT_LOAD);
  assign eval_beat   = query.valid && query.ready && (query.action == kai_pkg::ACT_EVAL);

  assign wr_ctl.end_we = load_beat && (32'(query.entry_index) < 32'(MAX_SEGMENTS));
  assign wr_ctl.ang_we = load_beat && (32'(query.entry_index) <= 32'(MAX_SEGMENTS));

  always_comb begin
    rd_end_addr = '0;
    rd_ang_addr = '0;
    unique case (state)
      S_IDLE: begin
        rd_end_addr = END_AW'(n_eff - 1'b1);
        rd_ang_addr = n_eff;
      end
      S_LAST:  rd_end_addr = END_AW'(h0);
      S_HINT:  rd_end_addr = (t_r > end_rd) ? END_AW'(h + 1'b1) : END_AW'(h - 1'b1);
      S_PREV:  rd_end_addr = '0;
      S_SCAN:  rd_end_addr = END_AW'(h + 1'b1);
      S_FETCH: begin
        rd_end_addr = END_AW'(h);
        rd_ang_addr = h;
      end
      S_GET0: begin
        rd_end_addr = END_AW'(h - 1'b1);
        rd_ang_addr = h + 1'b1;
      end
      default: begin
        rd_end_addr = '0;
        rd_ang_addr = '0;
      end
    endcase
  end

  kai_table #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_table (
    .clk         (clk),
    .wr_ctl      (wr_ctl),
    .wr_end_addr (END_AW'(query.entry_index)),
    .wr_ang_addr (CW'(query.entry_index)),
    .wr_end      (query.entry_end_time),
    .wr_ang      (query.entry_angle),
    .rd_end_addr (rd_end_addr),
    .rd_ang_addr (rd_ang_addr),
    .end_rd      (end_rd),
    .ang_rd      (ang_rd)
  );

  assign start_v   = (h == '0) ? '0 : end_rd;
  assign div_start = (state == S_GET1) && (stop_r > start_v);
  assign div_num   = (t_r > start_v) ? (t_r - start_v) : '0;
  assign div_den   = stop_r - start_v;

  kai_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign prod_sh = prod >>> FRACTION_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      seg_count <= kai_pkg::COUNT_W'(1);
      hint      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (seg_count_we) begin
        seg_count <= seg_count_wdata;
      end
      if (out_valid && result.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (eval_beat) begin
            t_r   <= query.query_time;
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (t_r >= end_rd) begin
            res_angle <= $signed(ang_rd);
            res_seg   <= n_eff - 1'b1;
            res_past  <= 1'b1;
            state     <= S_DONE;
          end else begin
            h     <= h0;
            state <= S_HINT;
          end
        end
        S_HINT: begin
          if (t_r > end_rd) begin
            h     <= h + 1'b1;
            state <= S_SCAN;
          end else if (h != '0) begin
            state <= S_PREV;
          end else begin
            state <= S_FETCH;
          end
        end
        S_PREV: begin
          if (t_r < end_rd) begin
            h     <= '0;
            state <= S_SCAN;
          end else begin
            state <= S_FETCH;
          end
        end
        S_SCAN: begin
          if ((h < n_eff - 1'b1) && (end_rd < t_r)) begin
            h <= h + 1'b1;
          end else begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          hint  <= h;
          state <= S_GET0;
        end
        S_GET0: begin
          stop_r <= end_rd;
          a0     <= $signed(ang_rd);
          state  <= S_GET1;
        end
        S_GET1: begin
          diff <= $signed({ang_rd[AW-1], ang_rd}) - $signed({a0[AW-1], a0});
          if (div_start) begin
            state <= S_DIV;
          end else begin
            frac  <= QW'(1) << FRACTION_BITS;
            state <= S_MUL;
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac  <= div_quot;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= diff * $signed({1'b0, frac});
          state <= S_SUM;
        end
        S_SUM: begin
          res_angle <= a0 + $signed(prod_sh[AW-1:0]);
          res_seg   <= h;
          res_past  <= 1'b0;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || result.ready) begin
            result.angle_out    <= res_angle;
            result.segment_used <= kai_pkg::SEG_W'(res_seg);
            result.past_end     <= res_past;
            out_valid           <= 1'b1;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result.valid = out_valid;

endmodule

### src/kai_table.sv
`timescale 1ns / 1ps

module kai_table #(
  parameter int  MAX_SEGMENTS = kai_pkg::MAX_SEGMENTS_DEF,
  localparam int END_AW       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
  localparam int ANG_AW       = $clog2(MAX_SEGMENTS + 1)
) (
  input  logic                        clk,
  input  kai_pkg::kai_wr_ctl_t        wr_ctl,
  input  logic [END_AW-1:0]           wr_end_addr,
  input  logic [ANG_AW-1:0]           wr_ang_addr,
  input  logic [kai_pkg::TIME_W-1:0]  wr_end,
  input  logic [kai_pkg::ANGLE_W-1:0] wr_ang,
  input  logic [END_AW-1:0]           rd_end_addr,
  input  logic [ANG_AW-1:0]           rd_ang_addr,
  output logic [kai_pkg::TIME_W-1:0]  end_rd,
  output logic [kai_pkg::ANGLE_W-1:0] ang_rd
);

  logic [kai_pkg::TIME_W-1:0]  end_mem [MAX_SEGMENTS];
  logic [kai_pkg::ANGLE_W-1:0] ang_mem [MAX_SEGMENTS + 1];

  always_ff @(posedge clk) begin
    if (wr_ctl.end_we) begin
      end_mem[wr_end_addr] <= wr_end;
    end
    end_rd <= end_mem[rd_end_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_ctl.ang_we) begin
      ang_mem[wr_ang_addr] <= wr_ang;
    end
    ang_rd <= ang_mem[rd_ang_addr];
  end

endmodule

### src/kai_div.sv
`timescale 1ns / 1ps

// restoring divider, dividend num << FRACTION_BITS, requires num <= den
module kai_div #(
  parameter int FRACTION_BITS = kai_pkg::FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [kai_pkg::TIME_W-1:0] num,
  input  logic [kai_pkg::TIME_W-1:0] den,
  output logic                       done,
  output logic [FRACTION_BITS:0]     quot
);

  localparam int CNT_W = $clog2(FRACTION_BITS + 1);
  localparam int TW    = kai_pkg::TIME_W;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [TW-1:0]    rem;
  logic [TW-1:0]    den_r;
  logic [TW:0]      rem2;
  logic             take;

  assign rem2 = {rem, 1'b0};
  assign take = rem2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNT_W'(FRACTION_BITS);
        den_r <= den;
        if (num >= den) begin
          rem  <= num - den;
          quot <= (FRACTION_BITS + 1)'(1);
        end else begin
          rem  <= num;
          quot <= '0;
        end
      end else if (busy) begin
        rem  <= take ? TW'(rem2 - {1'b0, den_r}) : TW'(rem2);
        quot <= {quot[FRACTION_BITS-1:0], take};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### src/kai_chk.sv
`timescale 1ns / 1ps

module kai_chk (
  input logic clk,
  input logic rst,
  input logic q_valid,
  input logic q_ready,
  input logic q_action,
  input logic r_valid,
  input logic r_ready
);

  logic q_beat;

  assign q_beat = q_valid && q_ready;

  // an evaluation holds the query side off until its result is staged
  a_eval_blocks: assert property (@(posedge clk) disable iff (rst)
    (q_beat && (q_action == kai_pkg::ACT_EVAL)) |=> !q_ready)
    else $error("query side still ready after an evaluate beat");

  // a load completes in its own cycle
  a_load_single: assert property (@(posedge clk) disable iff (rst)
    (q_beat && (q_action == kai_pkg::ACT_LOAD)) |=> q_ready)
    else $error("query side not ready after a load beat");

  // a new result is only staged by an evaluation in flight
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(r_valid) |-> $past(!q_ready))
    else $error("result beat appeared while idle");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (r_valid && !r_ready) |=> r_valid)
    else $error("result beat dropped before it was taken");

endmodule

bind keyframe_angle_interpolator_top kai_chk u_kai_chk (
  .clk      (clk),
  .rst      (rst),
  .q_valid  (query.valid),
  .q_ready  (query.ready),
  .q_action (query.action),
  .r_valid  (result.valid),
  .r_ready  (result.ready)
);

### tb/sv/kai_checker.sv
`timescale 1ns / 1ps

module kai_checker (
  input  logic                        clk,
  input  logic                        rst,
  kai_query_if                        query,
  kai_result_if                       result,
  input  logic                        seg_count_we,
  input  logic [kai_pkg::COUNT_W-1:0] seg_count_wdata,
  output int                          error_count,
  output int                          pending,
  output int                          results_checked,
  output int                          past_end_count,
  output int                          loads_seen
);

  localparam int     TIME_W   = kai_pkg::TIME_W;
  localparam int     ANGLE_W  = kai_pkg::ANGLE_W;
  localparam int     SEG_W    = kai_pkg::SEG_W;
  localparam int     COUNT_W  = kai_pkg::COUNT_W;
  localparam int     INDEX_W  = kai_pkg::INDEX_W;
  localparam int     MAX_SEG  = kai_pkg::MAX_SEGMENTS_DEF;
  localparam int     FRAC_W   = kai_pkg::FRACTION_BITS_DEF;
  localparam longint FRAC_ONE = longint'(1) << FRAC_W;
  localparam int     REPORT_MAX = 10;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle;
    logic [SEG_W-1:0]          segment;
    logic                      past_end;
  } angle_answer_t;

  logic [TIME_W-1:0]         end_tbl [MAX_SEG];
  logic signed [ANGLE_W-1:0] key_tbl [MAX_SEG+1];
  int                        seg_hint;
  logic [COUNT_W-1:0]        seg_count;
  angle_answer_t             answer_q [$];

  int errors;
  int checked;
  int past_hits;
  int loads;
  int reported;

  assign error_count     = errors;
  assign results_checked = checked;
  assign past_end_count  = past_hits;
  assign loads_seen      = loads;

  initial begin
    errors    = 0;
    checked   = 0;
    past_hits = 0;
    loads     = 0;
    reported  = 0;
  end

  function automatic void store_keyframe(input logic [INDEX_W-1:0] idx,
                                         input logic [TIME_W-1:0] end_t,
                                         input logic signed [ANGLE_W-1:0] ang);
    if (idx < MAX_SEG) end_tbl[idx] = end_t;
    if (idx <= MAX_SEG) key_tbl[idx] = ang;
  endfunction

  function automatic angle_answer_t interpolate_at(input logic [TIME_W-1:0] t);
    angle_answer_t     r;
    int                n;
    int                h;
    logic              walk;
    logic [TIME_W-1:0] seg_start;
    logic [TIME_W-1:0] seg_stop;
    longint            num;
    longint            frac;
    longint            a0;
    longint            a1;
    longint            ang;
    n = (seg_count == 0) ? 1 : ((seg_count > MAX_SEG) ? MAX_SEG : int'(seg_count));
    if (t >= end_tbl[n-1]) begin
      r.angle    = key_tbl[n];
      r.segment  = SEG_W'(n - 1);
      r.past_end = 1'b1;
      return r;
    end
    h = (seg_hint >= n) ? 0 : seg_hint;
    walk = 1'b1;
    if (t > end_tbl[h]) begin
      h++;
    end else if (h != 0 && t < end_tbl[h-1]) begin
      h = 0;
    end else begin
      walk = 1'b0;
    end
    if (walk) begin
      while (h < n - 1 && end_tbl[h] < t) h++;
    end
    seg_hint = h;
    seg_start = (h == 0) ? '0 : end_tbl[h-1];
    seg_stop  = end_tbl[h];
    if (seg_stop > seg_start) begin
      num  = (t > seg_start) ? longint'(t - seg_start) : 0;
      frac = (num << FRAC_W) / longint'(seg_stop - seg_start);
      if (frac > FRAC_ONE) frac = FRAC_ONE;
    end else begin
      frac = FRAC_ONE;
    end
    a0  = longint'(key_tbl[h]);
    a1  = longint'(key_tbl[h+1]);
    ang = a0 + (((a1 - a0) * frac) >>> FRAC_W);
    r.angle    = ANGLE_W'(ang);
    r.segment  = SEG_W'(h);
    r.past_end = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    angle_answer_t want;
    if (rst) begin
      seg_hint  = 0;
      seg_count = COUNT_W'(1);
      answer_q.delete();
    end else begin
      if (seg_count_we) seg_count = seg_count_wdata;

      if (result.valid && result.ready) begin
        if (answer_q.size() == 0) begin
          errors++;
          if (reported < REPORT_MAX) begin
            reported++;
            $display("%0t: result beat with nothing outstanding:", $time);
            $display("    angle %0d segment %0d past_end %0b",
                     $signed(result.angle_out), result.segment_used, result.past_end);
          end
        end else begin
          want = answer_q.pop_front();
          checked++;
          if (want.past_end) past_hits++;
          if (result.angle_out !== want.angle || result.segment_used !== want.segment ||
              result.past_end !== want.past_end) begin
            errors++;
            if (reported < REPORT_MAX) begin
              reported++;
              $display("%0t: result %0d mismatch: expected angle %0d segment %0d past_end %0b,",
                       $time, checked, $signed(want.angle), want.segment, want.past_end);
              $display("    got angle %0d segment %0d past_end %0b",
                       $signed(result.angle_out), result.segment_used, result.past_end);
            end
          end
        end
      end

      if (query.valid && query.ready) begin
        if (query.action == kai_pkg::ACT_LOAD) begin
          loads++;
          store_keyframe(query.entry_index, query.entry_end_time, query.entry_angle);
        end else begin
          answer_q.push_back(interpolate_at(query.query_time));
        end
      end
    end
    pending <= answer_q.size();
  end

endmodule

### tb/sv/tb_keyframe_angle_interpolator_top.sv
`timescale 1ns / 1ps

module tb_keyframe_angle_interpolator_top;

  localparam int TIME_W          = kai_pkg::TIME_W;
  localparam int ANGLE_W         = kai_pkg::ANGLE_W;
  localparam int INDEX_W         = kai_pkg::INDEX_W;
  localparam int COUNT_W         = kai_pkg::COUNT_W;
  localparam int MAX_SEG         = kai_pkg::MAX_SEGMENTS_DEF;
  localparam int PHASES          = 20;
  localparam int EVALS_PER_PHASE = 72;
  localparam int PRESSURE_PHASE  = 4;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 64;
  localparam int CYCLE_LIMIT     = 1_000_000;

  logic clk = 1'b0;
  logic rst;
  logic               seg_count_we;
  logic [COUNT_W-1:0] seg_count_wdata;

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int config_writes  = 0;
  int cycle_count    = 0;

  int error_count;
  int pending;
  int results_checked;
  int past_end_count;
  int loads_seen;

  always #5 clk = ~clk;

  kai_query_if  query_ch ();
  kai_result_if result_ch ();

  keyframe_angle_interpolator_top u_dut (
    .clk            (clk),
    .rst            (rst),
    .query          (query_ch),
    .result         (result_ch),
    .seg_count_we   (seg_count_we),
    .seg_count_wdata(seg_count_wdata)
  );

  kai_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .query          (query_ch),
    .result         (result_ch),
    .seg_count_we   (seg_count_we),
    .seg_count_wdata(seg_count_wdata),
    .error_count    (error_count),
    .pending        (pending),
    .results_checked(results_checked),
    .past_end_count (past_end_count),
    .loads_seen     (loads_seen)
  );

  // result side: random stalls plus the long hold-off
  initial begin : result_sink
    int hold_left;
    int holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (holds_taken != hold_requests) begin
        holds_taken++;
        hold_left = HOLD_CYCLES - 1;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[keyframe_angle_interpolator_top] ERROR");
    $finish;
  end

  function automatic logic [ANGLE_W-1:0] random_angle();
    if ($urandom_range(9) < 7) return $urandom;
    return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
  endfunction

  task automatic send_beat(input logic act, input logic [INDEX_W-1:0] idx,
                           input logic [TIME_W-1:0] end_t, input logic [ANGLE_W-1:0] ang,
                           input logic [TIME_W-1:0] qt);
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      query_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    query_ch.valid          <= 1'b1;
    query_ch.action         <= act;
    query_ch.entry_index    <= idx;
    query_ch.entry_end_time <= end_t;
    query_ch.entry_angle    <= ang;
    query_ch.query_time     <= qt;
    @(posedge clk);
    while (!query_ch.ready) @(posedge clk);
  endtask

  task automatic load_entry(input logic [INDEX_W-1:0] idx, input logic [TIME_W-1:0] end_t,
                            input logic [ANGLE_W-1:0] ang);
    send_beat(kai_pkg::ACT_LOAD, idx, end_t, ang, $urandom);
  endtask

  task automatic evaluate_at(input logic [TIME_W-1:0] qt);
    send_beat(kai_pkg::ACT_EVAL, INDEX_W'($urandom), $urandom, $urandom, qt);
  endtask

  // drain, let a trailing load settle, then write the count
  task automatic set_segment_count(input logic [COUNT_W-1:0] value);
    query_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    seg_count_we    <= 1'b1;
    seg_count_wdata <= value;
    @(posedge clk);
    seg_count_we <= 1'b0;
    config_writes++;
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0]  end_plan [MAX_SEG];
    logic [TIME_W-1:0]  acc;
    logic [TIME_W-1:0]  qt;
    logic [TIME_W-1:0]  last_end;
    logic [TIME_W-1:0]  stride;
    logic [COUNT_W-1:0] cnt;
    longint             tt;
    int                 n;
    int                 tmode;
    int                 pick;
    int                 slot;

    rst                     <= 1'b1;
    seg_count_we            <= 1'b0;
    seg_count_wdata         <= '0;
    query_ch.valid          <= 1'b0;
    query_ch.action         <= kai_pkg::ACT_LOAD;
    query_ch.entry_index    <= '0;
    query_ch.entry_end_time <= '0;
    query_ch.entry_angle    <= '0;
    query_ch.query_time     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: four segments, zero-length first segment, extreme angles
    set_segment_count(COUNT_W'(4));
    load_entry(INDEX_W'(0), 32'd0, 32'h7FFF_FFFF);
    load_entry(INDEX_W'(1), 32'd100, 32'h8000_0000);
    load_entry(INDEX_W'(2), 32'd100, 32'h0000_0000);
    load_entry(INDEX_W'(3), 32'd1000, 32'hFFFF_FFFF);
    load_entry(INDEX_W'(4), 32'hFFFF_FFFF, 32'h0100_0000);
    load_entry(INDEX_W'(16), 32'h0000_1234, 32'h0000_0055);
    load_entry(INDEX_W'(31), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    load_entry(INDEX_W'(17), 32'd0, 32'd0);
    evaluate_at(32'd0);
    evaluate_at(32'd1);
    evaluate_at(32'd50);
    evaluate_at(32'd100);
    evaluate_at(32'd101);
    evaluate_at(32'd550);
    evaluate_at(32'd999);
    evaluate_at(32'd1000);
    evaluate_at(32'hFFFF_FFFF);
    evaluate_at(32'd60);
    evaluate_at(32'd1);
    evaluate_at(32'd550);
    // hint now beyond the new count
    set_segment_count(COUNT_W'(2));
    evaluate_at(32'd40);
    load_entry(INDEX_W'(0), 32'd500, 32'h0040_0000);
    evaluate_at(32'd40);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct   = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 70;
        end
        default: begin
          send_gap_pct   = 26;
          recv_stall_pct = 26;
        end
      endcase
      case (phase)
        0: cnt = COUNT_W'(16);
        1: cnt = COUNT_W'(0);
        2: cnt = COUNT_W'(31);
        3: cnt = COUNT_W'(1);
        4: cnt = COUNT_W'(16);
        5: cnt = COUNT_W'(17);
        6: cnt = COUNT_W'(2);
        default: cnt = COUNT_W'($urandom_range(1, MAX_SEG));
      endcase
      set_segment_count(cnt);
      n = (cnt == 0) ? 1 : ((cnt > MAX_SEG) ? MAX_SEG : int'(cnt));

      // mostly ascending tables, short or wide spans, now and then unordered
      tmode = $urandom_range(0, 9);
      acc   = $urandom_range(0, 15);
      for (int i = 0; i < MAX_SEG; i++) begin
        if (tmode >= 8) begin
          end_plan[i] = $urandom;
        end else begin
          if (tmode >= 5) acc += $urandom_range(0, 32'h0FFF_FFFF);
          else if ($urandom_range(9) != 0) acc += $urandom_range(1, 600);
          end_plan[i] = acc;
        end
      end
      for (int i = 0; i <= MAX_SEG; i++)
        load_entry(INDEX_W'(i), (i < MAX_SEG) ? end_plan[i] : $urandom, random_angle());

      last_end = end_plan[n-1];
      stride   = last_end / (n * 4) + 1;
      qt       = '0;
      for (int k = 0; k < EVALS_PER_PHASE; k++) begin
        if (k % 24 == 23) begin
          if ($urandom_range(1) != 0) begin
            load_entry(INDEX_W'($urandom_range(17, 31)), $urandom, $urandom);
          end else begin
            slot = $urandom_range(0, MAX_SEG);
            load_entry(INDEX_W'(slot), (slot < MAX_SEG) ? end_plan[slot] : $urandom,
                       random_angle());
          end
        end
        if (phase == PRESSURE_PHASE && k == 10) hold_requests++;
        pick = $urandom_range(99);
        if (pick < 8) begin
          tt = longint'(last_end) + $urandom_range(0, 1000);
          qt = (tt > longint'(32'hFFFF_FFFF)) ? '1 : tt[TIME_W-1:0];
        end else if (pick < 15) begin
          qt = $urandom_range(0, qt);
        end else if (pick < 21) begin
          qt = end_plan[$urandom_range(0, n - 1)];
        end else if (pick < 25) begin
          qt = $urandom;
        end else begin
          tt = longint'(qt) + $urandom_range(0, stride);
          qt = (tt > longint'(32'hFFFF_FFFF)) ? '1 : tt[TIME_W-1:0];
        end
        evaluate_at(qt);
      end
    end

    query_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d keyframe loads and %0d checked evaluations, %0d of them past the end,",
             loads_seen, results_checked, past_end_count);
    $display("over %0d segment counts, with sender gaps, result stalls and a long hold-off.",
             config_writes);
    if (error_count == 0) begin
      $display("[keyframe_angle_interpolator_top] OK");
    end else begin
      $display("[keyframe_angle_interpolator_top] ERROR");
    end
    $finish;
  end

endmodule
